@@ hdl/lom_pkg.sv @@
package lom_pkg;

    localparam int MAX_ORDERS_DEF = 64;
    localparam int PRICE_BITS_DEF = 16;

    localparam logic ACT_PLACE  = 1'b0;
    localparam logic ACT_CANCEL = 1'b1;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    localparam logic [1:0] KIND_PLACED = 2'd0;
    localparam logic [1:0] KIND_TRADE  = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_FILL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] req_id;
        logic [31:0] buyer_id;
        logic [31:0] seller_id;
        logic [15:0] fill_price;
        logic [31:0] fill_qty;
        logic [31:0] remaining_qty;
        logic        rested;
        logic        book_full;
        logic        cancel_ok;
        logic        last;
    } res_t;

endpackage

@@ hdl/limit_order_matcher_top.sv @@
// Channel   Ports                                            Direction
// s_        s_valid/s_ready, action side price qty target_id  request in
// m_        m_valid/m_ready, kind req_id ... last             result out
//
// Each match pass reads the order table one entry per cycle through its
// registered read port. A cancel takes one pass. A place takes one pass per
// fill, plus one final pass unless the last fill uses up the quantity; a zero
// quantity takes no pass. aresetn clears the valid bits and sets the next id to one.
// s_ready is high only while idle; the sequencer holds when m_ valid is stalled.
module limit_order_matcher_top
    import lom_pkg::*;
#(
    parameter int MAX_ORDERS = MAX_ORDERS_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic                  s_side,
    input  logic [15:0]           s_price,
    input  logic [31:0]           s_qty,
    input  logic [31:0]           s_target_id,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_kind,
    output logic [31:0]           m_req_id,
    output logic [31:0]           m_buyer_id,
    output logic [31:0]           m_seller_id,
    output logic [15:0]           m_fill_price,
    output logic [31:0]           m_fill_qty,
    output logic [31:0]           m_remaining_qty,
    output logic                  m_rested,
    output logic                  m_book_full,
    output logic                  m_cancel_ok,
    output logic                  m_last
);

    localparam int IDX_W = $clog2(MAX_ORDERS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ORDERS - 1);

    // order table storage
    logic                  side_mem  [MAX_ORDERS];
    logic [PRICE_BITS-1:0] price_mem [MAX_ORDERS];
    logic [31:0]           qty_mem   [MAX_ORDERS];
    logic [31:0]           id_mem    [MAX_ORDERS];

    logic [MAX_ORDERS-1:0] valid_reg, valid_next;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic                  act_reg, act_next;
    logic                  side_reg, side_next;
    logic [PRICE_BITS-1:0] price_reg, price_next;
    logic [31:0]           qty_reg, qty_next;
    logic [31:0]           tgt_reg, tgt_next;
    logic [31:0]           oid_reg, oid_next;
    logic [31:0]           next_id_reg, next_id_next;

    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  cmp_en_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic                  vld_d_reg;
    logic                  rd_side_reg;
    logic [PRICE_BITS-1:0] rd_price_reg;
    logic [31:0]           rd_qty_reg;
    logic [31:0]           rd_id_reg;

    logic                  best_found_reg, best_found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [PRICE_BITS-1:0] best_price_reg, best_price_next;
    logic [31:0]           best_age_reg, best_age_next;
    logic [31:0]           best_qty_reg, best_qty_next;
    logic [31:0]           best_id_reg, best_id_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;

    res_t pend_reg, pend_next;
    logic pend_valid_reg, pend_valid_next;
    res_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;

    logic                  wr_rest, wr_qty;
    logic [31:0]           new_rest_qty;

    logic [31:0]           in_price_ext;
    logic [31:0]           best_price_ext;
    logic [31:0]           age;
    logic [31:0]           fill_qty;
    logic                  cand, better;
    res_t                  r;

    assign in_price_ext   = 32'(s_price);
    assign best_price_ext = 32'(best_price_reg);
    assign age            = next_id_reg - rd_id_reg;
    assign fill_qty       = (qty_reg < best_qty_reg) ? qty_reg : best_qty_reg;
    assign new_rest_qty   = best_qty_reg - fill_qty;

    // compare the entry read last cycle against the running best
    always_comb begin
        cand = vld_d_reg && (rd_side_reg != side_reg) &&
               ((side_reg == SIDE_BUY) ? (rd_price_reg <= price_reg)
                                       : (rd_price_reg >= price_reg));
        if (!best_found_reg) begin
            better = 1'b1;
        end else if (rd_price_reg != best_price_reg) begin
            better = (side_reg == SIDE_BUY) ? (rd_price_reg < best_price_reg)
                                            : (rd_price_reg > best_price_reg);
        end else begin
            better = age > best_age_reg;
        end
    end

    // sequencer and datapath next values
    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        act_next        = act_reg;
        side_next       = side_reg;
        price_next      = price_reg;
        qty_next        = qty_reg;
        tgt_next        = tgt_reg;
        oid_next        = oid_reg;
        next_id_next    = next_id_reg;
        scan_idx_next   = scan_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_price_next = best_price_reg;
        best_age_next   = best_age_reg;
        best_qty_next   = best_qty_reg;
        best_id_next    = best_id_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        valid_next      = valid_reg;
        wr_rest         = 1'b0;
        wr_qty          = 1'b0;
        r               = '0;

        // fold in the compared entry
        if (cmp_en_reg) begin
            if (act_reg == ACT_CANCEL) begin
                if (vld_d_reg && rd_id_reg == tgt_reg && !best_found_reg) begin
                    best_found_next = 1'b1;
                    best_idx_next   = cmp_idx_reg;
                end
            end else begin
                if (cand && better) begin
                    best_found_next = 1'b1;
                    best_idx_next   = cmp_idx_reg;
                    best_price_next = rd_price_reg;
                    best_age_next   = age;
                    best_qty_next   = rd_qty_reg;
                    best_id_next    = rd_id_reg;
                end
                if (!vld_d_reg && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next        = s_action;
                    side_next       = s_side;
                    price_next      = in_price_ext[PRICE_BITS-1:0];
                    qty_next        = s_qty;
                    tgt_next        = s_target_id;
                    scan_idx_next   = '0;
                    best_found_next = 1'b0;
                    free_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    if (s_action == ACT_CANCEL) begin
                        state_next = ST_SCAN;
                    end else begin
                        oid_next     = next_id_reg;
                        next_id_next = next_id_reg + 32'd1;
                        if (s_qty == '0) begin
                            r.kind     = KIND_PLACED;
                            r.req_id   = next_id_reg;
                            r.last     = 1'b1;
                            pend_next  = r;
                            ret_next   = ST_IDLE;
                            state_next = ST_EMIT;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (act_reg == ACT_CANCEL) begin
                    if (best_found_reg) begin
                        valid_next[best_idx_reg] = 1'b0;
                    end
                    r.kind      = KIND_CANCEL;
                    r.req_id    = tgt_reg;
                    r.cancel_ok = best_found_reg;
                    r.last      = 1'b1;
                    pend_next   = r;
                    ret_next    = ST_IDLE;
                    state_next  = ST_EMIT;
                end else if (best_found_reg) begin
                    // flush the previous trade as a middle result first
                    if (pend_valid_reg) begin
                        ret_next   = ST_FILL;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_FILL;
                    end
                end else begin
                    // no more crossing orders: rest the remainder if a free slot was found
                    if (pend_valid_reg) begin
                        r = pend_reg;
                    end else begin
                        r.kind   = KIND_PLACED;
                        r.req_id = oid_reg;
                    end
                    r.remaining_qty = qty_reg;
                    r.rested        = free_found_reg;
                    r.book_full     = !free_found_reg;
                    r.last          = 1'b1;
                    if (free_found_reg) begin
                        wr_rest                  = 1'b1;
                        valid_next[free_idx_reg] = 1'b1;
                    end
                    pend_next  = r;
                    ret_next   = ST_IDLE;
                    state_next = ST_EMIT;
                end
            end
            ST_FILL: begin
                wr_qty   = 1'b1;
                qty_next = qty_reg - fill_qty;
                if (new_rest_qty == '0) begin
                    valid_next[best_idx_reg] = 1'b0;
                end
                r.kind       = KIND_TRADE;
                r.req_id     = oid_reg;
                r.buyer_id   = (side_reg == SIDE_BUY) ? oid_reg : best_id_reg;
                r.seller_id  = (side_reg == SIDE_BUY) ? best_id_reg : oid_reg;
                r.fill_price = best_price_ext[15:0];
                r.fill_qty   = fill_qty;
                r.last       = (qty_reg == fill_qty);
                pend_next       = r;
                pend_valid_next = 1'b1;
                if (qty_reg == fill_qty) begin
                    ret_next   = ST_IDLE;
                    state_next = ST_EMIT;
                end else begin
                    scan_idx_next   = '0;
                    best_found_next = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next        = pend_reg;
                    m_valid_next    = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ret_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            valid_reg      <= '0;
            next_id_reg    <= 32'd1;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            cmp_en_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            valid_reg      <= valid_next;
            next_id_reg    <= next_id_next;
            m_valid_reg    <= m_valid_next;
            pend_valid_reg <= pend_valid_next;
            cmp_en_reg     <= (state_reg == ST_SCAN);
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        side_reg       <= side_next;
        price_reg      <= price_next;
        qty_reg        <= qty_next;
        tgt_reg        <= tgt_next;
        oid_reg        <= oid_next;
        scan_idx_reg   <= scan_idx_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_price_reg <= best_price_next;
        best_age_reg   <= best_age_next;
        best_qty_reg   <= best_qty_next;
        best_id_reg    <= best_id_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        pend_reg       <= pend_next;
        out_reg        <= out_next;
        cmp_idx_reg    <= scan_idx_reg;
        vld_d_reg      <= valid_reg[scan_idx_reg];
    end

    // order table: at most one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_rest) begin
            side_mem[free_idx_reg]  <= side_reg;
            price_mem[free_idx_reg] <= price_reg;
            qty_mem[free_idx_reg]   <= qty_reg;
            id_mem[free_idx_reg]    <= oid_reg;
        end else if (wr_qty) begin
            qty_mem[best_idx_reg] <= new_rest_qty;
        end
        rd_side_reg  <= side_mem[scan_idx_reg];
        rd_price_reg <= price_mem[scan_idx_reg];
        rd_qty_reg   <= qty_mem[scan_idx_reg];
        rd_id_reg    <= id_mem[scan_idx_reg];
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_kind          = out_reg.kind;
    assign m_req_id        = out_reg.req_id;
    assign m_buyer_id      = out_reg.buyer_id;
    assign m_seller_id     = out_reg.seller_id;
    assign m_fill_price    = out_reg.fill_price;
    assign m_fill_qty      = out_reg.fill_qty;
    assign m_remaining_qty = out_reg.remaining_qty;
    assign m_rested        = out_reg.rested;
    assign m_book_full     = out_reg.book_full;
    assign m_cancel_ok     = out_reg.cancel_ok;
    assign m_last          = out_reg.last;

endmodule
